>>> rtl/core/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared clocked assertion wrappers for the tessellator RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, switched off while reset is held low.
`define QBT_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Clocked property that also holds through reset.
`define QBT_ASSERT_RST(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/core/qbt_pkg.sv
// ---------------------------------------------------------------------------
// qbt_pkg
// Widths, types and constants shared by the tessellator modules.
// ---------------------------------------------------------------------------
`default_nettype none

package qbt_pkg;

    localparam int COORD_BITS  = 12;
    localparam int STEP_BITS   = 6;
    localparam int MAX_STEPS   = 63;
    localparam int DEF_STEPS   = 16;

    // steps^2 and twice steps^2
    localparam int SQ_W        = 2 * STEP_BITS;
    localparam int REM_W       = SQ_W + 1;

    // signed deltas are offset by 2^OFF_EXP divisors so the dividend is positive
    localparam int OFF_EXP     = COORD_BITS + 2;
    localparam int DIV_STEPS   = COORD_BITS + 3;
    localparam int DIV_CNT_W   = $clog2(DIV_STEPS);
    localparam int DVD_W       = DIV_STEPS + SQ_W;
    localparam int DELTA_W     = COORD_BITS + STEP_BITS + 2;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam int IN_W        = ((6 * COORD_BITS + 7) / 8) * 8;
    localparam int OUT_W       = ((2 * COORD_BITS + STEP_BITS + 7) / 8) * 8;

    typedef logic signed [COORD_BITS-1:0] t_coord;
    typedef logic        [STEP_BITS-1:0]  t_steps;
    typedef logic        [SQ_W-1:0]       t_sq;
    typedef logic        [REM_W-1:0]      t_rem;
    typedef logic signed [DELTA_W-1:0]    t_delta;
    typedef logic        [DVD_W-1:0]      t_dvd;

    // one segment's control points
    typedef struct packed {
        t_coord sx;
        t_coord sy;
        t_coord mx;
        t_coord my;
        t_coord ex;
        t_coord ey;
    } t_pts;

    // mixed-radix accumulator, value = q * 2d + r with 0 <= r < 2d
    typedef struct packed {
        t_coord q;
        t_rem   r;
        t_coord qd;
        t_rem   rd;
        t_coord qe;
        t_rem   re;
    } t_acc;

    typedef struct packed {
        t_steps s;
        t_sq    d;
        t_acc   x;
        t_acc   y;
    } t_seg;

endpackage

`default_nettype wire

>>> rtl/core/qbt_div.sv
// ---------------------------------------------------------------------------
// qbt_div
// Restoring divider, one quotient bit per cycle, unsigned dividend.
// ---------------------------------------------------------------------------
`default_nettype none

module qbt_div (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_start,
    input  wire qbt_pkg::t_dvd   i_dividend,
    input  wire qbt_pkg::t_sq    i_divisor,
    output logic                 o_done,
    output qbt_pkg::t_coord      o_quot,
    output qbt_pkg::t_sq         o_rem
);

    localparam int CW    = qbt_pkg::COORD_BITS;
    localparam int CNT_W = qbt_pkg::DIV_CNT_W;
    localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(qbt_pkg::DIV_STEPS - 1);

    logic              r_run,  n_run;
    logic              r_done, n_done;
    logic [CNT_W-1:0]  r_cnt,  n_cnt;
    qbt_pkg::t_dvd     r_rem,  n_rem;
    qbt_pkg::t_dvd     r_dsh,  n_dsh;
    logic [CW-1:0]     r_quot, n_quot;
    logic              fit;

    always_comb begin
        n_run  = r_run;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_dsh  = r_dsh;
        n_quot = r_quot;
        fit    = (r_rem >= r_dsh);
        if (i_start) begin
            n_run  = 1'b1;
            n_cnt  = '0;
            n_rem  = i_dividend;
            n_dsh  = qbt_pkg::t_dvd'(i_divisor) << (qbt_pkg::DIV_STEPS - 1);
            n_quot = '0;
        end else if (r_run) begin
            if (fit) begin
                n_rem = r_rem - r_dsh;
            end
            n_dsh  = r_dsh >> 1;
            n_quot = {r_quot[CW-2:0], fit};
            n_cnt  = r_cnt + 1'b1;
            if (r_cnt == LAST_CNT) begin
                n_run  = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_run  <= n_run;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem  <= n_rem;
        r_dsh  <= n_dsh;
        r_quot <= n_quot;
    end

    assign o_done = r_done;
    assign o_quot = $signed(r_quot);
    assign o_rem  = r_rem[qbt_pkg::SQ_W-1:0];

endmodule

`default_nettype wire

>>> rtl/core/qbt_front.sv
// ---------------------------------------------------------------------------
// qbt_front
// Takes a segment, splits its deltas into multiples of steps^2 plus remainder.
// ---------------------------------------------------------------------------
`default_nettype none

module qbt_front (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    output logic                  o_ready,
    input  wire qbt_pkg::t_pts    i_pts,
    input  wire qbt_pkg::t_steps  i_steps,
    output logic                  o_push,
    input  wire logic             i_full,
    output qbt_pkg::t_seg         o_seg
);

    localparam int DW = qbt_pkg::DELTA_W;
    localparam int VW = qbt_pkg::DVD_W;

    typedef enum logic [3:0] {
        F_IDLE = 4'b0001,
        F_PREP = 4'b0010,
        F_RUN  = 4'b0100,
        F_PUSH = 4'b1000
    } t_fstate;

    t_fstate          r_state, n_state;
    qbt_pkg::t_pts    r_pts;
    qbt_pkg::t_steps  r_s;

    qbt_pkg::t_sq     sq;
    logic             start;
    logic [3:0]       done;
    qbt_pkg::t_dvd    dvd [4];
    qbt_pkg::t_coord  quot [4];
    qbt_pkg::t_sq     rem [4];

    // N(1) - N(0) = 2s(p1 - p0) + (p0 - 2p1 + p2)
    function automatic qbt_pkg::t_delta first_diff(
        input qbt_pkg::t_coord p0,
        input qbt_pkg::t_coord p1,
        input qbt_pkg::t_coord p2,
        input qbt_pkg::t_steps s
    );
        qbt_pkg::t_delta a;
        qbt_pkg::t_delta b;
        a = qbt_pkg::t_delta'(p0) - (qbt_pkg::t_delta'(p1) <<< 1) + qbt_pkg::t_delta'(p2);
        b = (qbt_pkg::t_delta'($signed({1'b0, s}))
             * (qbt_pkg::t_delta'(p1) - qbt_pkg::t_delta'(p0))) <<< 1;
        return a + b;
    endfunction

    // constant second difference, 2 * (p0 - 2p1 + p2)
    function automatic qbt_pkg::t_delta second_diff(
        input qbt_pkg::t_coord p0,
        input qbt_pkg::t_coord p1,
        input qbt_pkg::t_coord p2
    );
        qbt_pkg::t_delta a;
        a = qbt_pkg::t_delta'(p0) - (qbt_pkg::t_delta'(p1) <<< 1) + qbt_pkg::t_delta'(p2);
        return a <<< 1;
    endfunction

    // bias by 2^OFF_EXP divisors; quotient bias vanishes modulo the coord width
    function automatic qbt_pkg::t_dvd bias(
        input qbt_pkg::t_delta v,
        input qbt_pkg::t_sq    d
    );
        qbt_pkg::t_dvd ext;
        ext = {{(VW - DW){v[DW-1]}}, v};
        return ext + (qbt_pkg::t_dvd'(d) << qbt_pkg::OFF_EXP);
    endfunction

    always_comb begin
        sq     = qbt_pkg::t_sq'(r_s) * qbt_pkg::t_sq'(r_s);
        start  = (r_state == F_PREP);
        dvd[0] = bias(first_diff(r_pts.sx, r_pts.mx, r_pts.ex, r_s), sq);
        dvd[1] = bias(second_diff(r_pts.sx, r_pts.mx, r_pts.ex), sq);
        dvd[2] = bias(first_diff(r_pts.sy, r_pts.my, r_pts.ey, r_s), sq);
        dvd[3] = bias(second_diff(r_pts.sy, r_pts.my, r_pts.ey), sq);
    end

    for (genvar g = 0; g < 4; g++) begin : g_div
        qbt_div u_div (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_start    (start),
            .i_dividend (dvd[g]),
            .i_divisor  (sq),
            .o_done     (done[g]),
            .o_quot     (quot[g]),
            .o_rem      (rem[g])
        );
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            F_IDLE: begin
                if (i_valid) n_state = F_PREP;
            end
            F_PREP: begin
                n_state = F_RUN;
            end
            F_RUN: begin
                if (&done) n_state = F_PUSH;
            end
            F_PUSH: begin
                if (!i_full) n_state = F_IDLE;
            end
            default: begin
                n_state = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_pts <= i_pts;
            r_s   <= i_steps;
        end
    end

    assign o_ready = (r_state == F_IDLE);
    assign o_push  = (r_state == F_PUSH) && !i_full;

    always_comb begin
        o_seg.s    = r_s;
        o_seg.d    = sq;
        o_seg.x.q  = r_pts.sx;
        o_seg.x.r  = qbt_pkg::t_rem'(sq);
        o_seg.x.qd = quot[0];
        o_seg.x.rd = {rem[0], 1'b0};
        o_seg.x.qe = quot[1];
        o_seg.x.re = {rem[1], 1'b0};
        o_seg.y.q  = r_pts.sy;
        o_seg.y.r  = qbt_pkg::t_rem'(sq);
        o_seg.y.qd = quot[2];
        o_seg.y.rd = {rem[2], 1'b0};
        o_seg.y.qe = quot[3];
        o_seg.y.re = {rem[3], 1'b0};
    end

endmodule

`default_nettype wire

>>> rtl/core/qbt_fifo.sv
// ---------------------------------------------------------------------------
// qbt_fifo
// Short segment queue between the front and back halves.
// ---------------------------------------------------------------------------
`default_nettype none

module qbt_fifo (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire qbt_pkg::t_seg  i_seg,
    output logic                o_full,
    input  wire logic           i_pop,
    output logic                o_valid,
    output qbt_pkg::t_seg       o_seg
);

    localparam int PW = qbt_pkg::QPTR_W;
    localparam int CW = PW + 1;
    localparam logic [PW-1:0] LAST_PTR = PW'(qbt_pkg::QUEUE_DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(qbt_pkg::QUEUE_DEPTH);

    qbt_pkg::t_seg  r_mem [qbt_pkg::QUEUE_DEPTH];
    qbt_pkg::t_seg  r_head;
    logic [PW-1:0]  r_wr, r_rd;
    logic [PW-1:0]  n_rd;
    logic [CW-1:0]  r_cnt;

    assign n_rd = i_pop ? ((r_rd == LAST_PTR) ? '0 : r_rd + 1'b1) : r_rd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == LAST_PTR) ? '0 : r_wr + 1'b1;
            end
            r_rd <= n_rd;
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_seg;
        end
        // head word, taken straight from the input when it lands in the head slot
        if (i_push && (r_wr == n_rd)) begin
            r_head <= i_seg;
        end else begin
            r_head <= r_mem[n_rd];
        end
    end

    assign o_full  = (r_cnt == FULL_CNT);
    assign o_valid = (r_cnt != '0);
    assign o_seg   = r_head;

endmodule

`default_nettype wire

>>> rtl/core/qbt_back.sv
// ---------------------------------------------------------------------------
// qbt_back
// Forward-difference stepper, one curve point per cycle into an output register, unless the output stalls.
// ---------------------------------------------------------------------------
`default_nettype none

module qbt_back (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    input  wire qbt_pkg::t_seg  i_seg,
    output logic                o_pop,
    output logic                o_valid,
    input  wire logic           i_ready,
    output qbt_pkg::t_coord     o_x,
    output qbt_pkg::t_coord     o_y,
    output qbt_pkg::t_steps     o_idx,
    output logic                o_last
);

    localparam int RW = qbt_pkg::REM_W;

    logic             r_busy;
    logic             r_out_valid;
    qbt_pkg::t_steps  r_idx;
    qbt_pkg::t_steps  r_s;
    qbt_pkg::t_rem    r_d2;
    qbt_pkg::t_acc    r_x, r_y;
    qbt_pkg::t_coord  r_ox, r_oy;
    qbt_pkg::t_steps  r_oidx;
    logic             r_olast;

    logic emit;
    logic load;
    logic last;

    // mixed-radix step: remainders stay below 2d, overflow carries into q
    function automatic qbt_pkg::t_acc advance(
        input qbt_pkg::t_acc a,
        input qbt_pkg::t_rem d2
    );
        logic [RW:0]    s1;
        logic [RW:0]    s2;
        logic           c1;
        logic           c2;
        qbt_pkg::t_acc  n;
        n    = a;
        s1   = {1'b0, a.r} + {1'b0, a.rd};
        c1   = (s1 >= {1'b0, d2});
        n.r  = c1 ? qbt_pkg::t_rem'(s1 - {1'b0, d2}) : qbt_pkg::t_rem'(s1);
        n.q  = a.q + a.qd + qbt_pkg::t_coord'(c1);
        s2   = {1'b0, a.rd} + {1'b0, a.re};
        c2   = (s2 >= {1'b0, d2});
        n.rd = c2 ? qbt_pkg::t_rem'(s2 - {1'b0, d2}) : qbt_pkg::t_rem'(s2);
        n.qd = a.qd + a.qe + qbt_pkg::t_coord'(c2);
        return n;
    endfunction

    assign emit  = r_busy && (!r_out_valid || i_ready);
    assign load  = !r_busy && i_valid;
    assign last  = (r_idx == r_s);
    assign o_pop = load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (load) begin
                r_busy <= 1'b1;
            end else if (emit && last) begin
                r_busy <= 1'b0;
            end
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_x   <= i_seg.x;
            r_y   <= i_seg.y;
            r_s   <= i_seg.s;
            r_d2  <= {i_seg.d, 1'b0};
            r_idx <= '0;
        end else if (emit) begin
            r_x   <= advance(r_x, r_d2);
            r_y   <= advance(r_y, r_d2);
            r_idx <= r_idx + 1'b1;
        end
        if (emit) begin
            r_ox    <= r_x.q;
            r_oy    <= r_y.q;
            r_oidx  <= r_idx;
            r_olast <= last;
        end
    end

    assign o_valid = r_out_valid;
    assign o_x     = r_ox;
    assign o_y     = r_oy;
    assign o_idx   = r_oidx;
    assign o_last  = r_olast;

endmodule

`default_nettype wire

>>> rtl/core/quadratic_bezier_tessellator.sv
// ---------------------------------------------------------------------------
// quadratic_bezier_tessellator
// Quadratic curve segment in, steps+1 rounded curve points out.
// ---------------------------------------------------------------------------
// Each input word is one quadratic segment (start, mid and end control point,
// signed pixels); the block returns steps+1 output words for t = i/steps,
// i = 0..steps, each the exact curve value rounded to the nearest pixel with
// halves going up, tagged with its index and with tlast on the final point.
// The steps register (reset 16) is written through i_cfg_we/i_cfg_wdata;
// the user must write it only while the block is idle, which the block
// itself does not enforce; 0 behaves as 1. In the front end a segment goes
// through capture, set-up, a shared-divisor division of the first and second
// differences for x and y in parallel, and hand-off; the back end then pops
// it from the queue and a forward-difference stepper gives one point per
// cycle while the output is not stalled. The two halves overlap through a
// two-deep queue, so the front end can take a new segment while the back
// end still steps an earlier one. Output words sit in a register, so the
// next segment is taken while a finished point waits.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module quadratic_bezier_tessellator (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // steps register write
    input  wire logic                          i_cfg_we,
    input  wire logic [qbt_pkg::STEP_BITS-1:0] i_cfg_wdata,
    // segment words
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    // start_x, start_y, mid_x, mid_y, end_x, end_y (lowest bits first)
    input  wire logic [qbt_pkg::IN_W-1:0]      s_axis_tdata,
    // point words
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    // point_x, point_y, point_index, zero fill (lowest bits first)
    output logic [qbt_pkg::OUT_W-1:0]          m_axis_tdata,
    // last_point
    output logic                               m_axis_tlast
);

    localparam int CW = qbt_pkg::COORD_BITS;
    localparam int SB = qbt_pkg::STEP_BITS;
    localparam qbt_pkg::t_steps DEF_S = SB'(qbt_pkg::DEF_STEPS);
    localparam qbt_pkg::t_steps MAX_S = SB'(qbt_pkg::MAX_STEPS);
    localparam qbt_pkg::t_steps MIN_S = SB'(1);

    qbt_pkg::t_steps  r_steps;
    qbt_pkg::t_steps  s_eff;
    qbt_pkg::t_pts    pts;

    logic             q_push, q_full, q_pop, q_valid;
    qbt_pkg::t_seg    seg_in, seg_out;

    qbt_pkg::t_coord  out_x, out_y;
    qbt_pkg::t_steps  out_idx;

    // steps register, no read-back
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_steps <= DEF_S;
        end else if (i_cfg_we) begin
            r_steps <= i_cfg_wdata;
        end
    end

    // zero steps runs as one interval; clamp kept for narrower MAX_STEPS
    always_comb begin
        if (r_steps == '0) begin
            s_eff = MIN_S;
        end else if (r_steps > MAX_S) begin
            s_eff = MAX_S;
        end else begin
            s_eff = r_steps;
        end
    end

    always_comb begin
        pts.sx = $signed(s_axis_tdata[0*CW +: CW]);
        pts.sy = $signed(s_axis_tdata[1*CW +: CW]);
        pts.mx = $signed(s_axis_tdata[2*CW +: CW]);
        pts.my = $signed(s_axis_tdata[3*CW +: CW]);
        pts.ex = $signed(s_axis_tdata[4*CW +: CW]);
        pts.ey = $signed(s_axis_tdata[5*CW +: CW]);
    end

    // front: capture and divide the differences by steps^2
    qbt_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_pts   (pts),
        .i_steps (s_eff),
        .o_push  (q_push),
        .i_full  (q_full),
        .o_seg   (seg_in)
    );

    qbt_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_seg   (seg_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_seg   (seg_out)
    );

    // back: one point per cycle by forward differences, unless the output stalls
    qbt_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .i_seg   (seg_out),
        .o_pop   (q_pop),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_x     (out_x),
        .o_y     (out_y),
        .o_idx   (out_idx),
        .o_last  (m_axis_tlast)
    );

    always_comb begin
        m_axis_tdata                 = '0;
        m_axis_tdata[0 +: CW]        = out_x;
        m_axis_tdata[CW +: CW]       = out_y;
        m_axis_tdata[2*CW +: SB]     = out_idx;
    end

    // points of one segment leave in index order
    `QBT_ASSERT(a_idx_seq, i_clk, i_rst_n, m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> !m_axis_tvalid || (out_idx == $past(out_idx) + 1'b1), "point index not consecutive")
    // front holds off new segments while one is being set up
    `QBT_ASSERT(a_in_busy, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready |=> !s_axis_tready, "segment taken while front busy")
    `QBT_ASSERT_RST(a_rst_out, i_clk, !i_rst_n |=> !m_axis_tvalid, "output valid after reset")

endmodule

`default_nettype wire

>>> sim/quadratic_bezier_tessellator_tb.sv
// ---------------------------------------------------------------------------
// quadratic_bezier_tessellator_tb
// Self-checking bench for the quadratic curve tessellator.
// ---------------------------------------------------------------------------
// Segment words go in on the slave stream and point words come back on the
// master stream. A scoreboard works out every curve point in exact integer
// arithmetic: the Bernstein weights over steps^2, with round-half-up. It
// compares each returned word field by field, tlast included, in order.
// A directed opening covers coordinate extremes, rounding ties both ways,
// zero steps, one step, the reset default and the 63-step maximum. Random
// phases follow with fresh step counts. Both streams idle at random, with
// calm stretches. The steps register is only written with the pipe empty.
// ---------------------------------------------------------------------------

module quadratic_bezier_tessellator_tb;

    timeunit 1ns;
    timeprecision 1ps;

    typedef qbt_pkg::t_coord t_coord;
    typedef qbt_pkg::t_steps t_steps;

    localparam int     COORD_BITS      = qbt_pkg::COORD_BITS;
    localparam int     STEP_BITS       = qbt_pkg::STEP_BITS;
    localparam int     DEF_STEPS       = qbt_pkg::DEF_STEPS;
    localparam int     MAX_STEPS       = qbt_pkg::MAX_STEPS;
    localparam int     IN_W            = qbt_pkg::IN_W;
    localparam int     OUT_W           = qbt_pkg::OUT_W;

    localparam int     GAP_MAX         = 17;
    localparam int     RANDOM_PHASES   = 6;
    localparam int     SEGS_PER_PHASE  = 25;
    localparam int     SETTLE_CYCLES   = 4;
    // margin after the last drain; allow plenty
    localparam int     TAIL_CYCLES     = 120;
    localparam int     CYCLE_LIMIT     = 1_000_000;
    localparam t_coord COORD_MIN       = t_coord'(-(2 ** (COORD_BITS - 1)));
    localparam t_coord COORD_MAX       = t_coord'((2 ** (COORD_BITS - 1)) - 1);

    // one expected point word
    typedef struct packed {
        t_coord x;
        t_coord y;
        t_steps idx;
        logic   last;
    } t_point;

    // -----------------------------------------------------------------------
    // Scoreboard: curve point prediction and in-order comparison
    // -----------------------------------------------------------------------
    class curve_scoreboard;
        t_steps steps;
        t_point pending_pts[$];
        int     errors;
        int     segments;
        int     points;

        function new();
            steps    = t_steps'(DEF_STEPS);
            errors   = 0;
            segments = 0;
            points   = 0;
        endfunction

        function int pending();
            return pending_pts.size();
        endfunction

        // weighted sum over s^2, nearest pixel, halves towards +inf
        function t_coord blend(longint p0, longint p1, longint p2, longint s, longint i);
            longint num;
            longint n2;
            longint d2;
            longint q;
            num = (s - i) * (s - i) * p0 + 2 * i * (s - i) * p1 + i * i * p2;
            n2  = 2 * num + s * s;
            d2  = 2 * s * s;
            q   = n2 / d2;
            // division truncates, so step down for negative remainders
            if ((n2 % d2) != 0 && n2 < 0)
                q = q - 1;
            return t_coord'(q);
        endfunction

        function void note_segment(t_coord sx, t_coord sy, t_coord mx, t_coord my,
                                   t_coord ex, t_coord ey);
            int     s;
            int     i;
            t_point p;
            // zero steps behaves as one
            s = (steps == 0) ? 1 : int'(steps);
            for (i = 0; i <= s; i++) begin
                p.x    = blend(sx, mx, ex, s, i);
                p.y    = blend(sy, my, ey, s, i);
                p.idx  = t_steps'(i);
                p.last = (i == s);
                pending_pts.push_back(p);
            end
            segments++;
        endfunction

        function void mismatch(string field, int want, int got);
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
        endfunction

        function void check_point(logic [OUT_W-1:0] data, logic last);
            t_point want;
            t_point got;
            got.x    = data[COORD_BITS-1:0];
            got.y    = data[2*COORD_BITS-1:COORD_BITS];
            got.idx  = data[2*COORD_BITS+STEP_BITS-1:2*COORD_BITS];
            got.last = last;
            if (pending_pts.size() == 0) begin
                errors++;
                $display(
                    "%0t: unexpected point word, expected none, actual %0d/%0d idx %0d last %0b",
                    $time, got.x, got.y, got.idx, got.last);
                return;
            end
            want = pending_pts.pop_front();
            points++;
            if (got.x !== want.x)
                mismatch("point_x", want.x, got.x);
            if (got.y !== want.y)
                mismatch("point_y", want.y, got.y);
            if (got.idx !== want.idx)
                mismatch("point_index", want.idx, got.idx);
            if (got.last !== want.last)
                mismatch("last_point", want.last, got.last);
        endfunction
    endclass

    // -----------------------------------------------------------------------
    // DUT
    // -----------------------------------------------------------------------
    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic [STEP_BITS-1:0] i_cfg_wdata;
    logic               s_axis_tvalid;
    logic               s_axis_tready;
    logic [IN_W-1:0]    s_axis_tdata;
    logic               m_axis_tvalid;
    logic               m_axis_tready;
    logic [OUT_W-1:0]   m_axis_tdata;
    logic               m_axis_tlast;

    quadratic_bezier_tessellator i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    curve_scoreboard sb;
    int              cycles;
    int              send_calm;
    int              recv_calm;
    int              steps_writes;
    int              directed_segs;

    // -----------------------------------------------------------------------
    // Clock and watchdog
    // -----------------------------------------------------------------------
    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    initial begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("%0t: watchdog expired, %0d point words still owed", $time, sb.pending());
        $display("TEST FAILED");
        $finish;
    end

    // -----------------------------------------------------------------------
    // Helpers
    // -----------------------------------------------------------------------

    // idle cycles before a word; calm stretches give back-to-back traffic
    function automatic int draw_wait(inout int calm_left);
        if (calm_left > 0) begin
            calm_left--;
            return 0;
        end
        if ($urandom_range(0, 11) == 0) begin
            calm_left = $urandom_range(6, 30);
            return 0;
        end
        return $urandom_range(0, GAP_MAX);
    endfunction

    // mostly full range, with extremes and near-zero values mixed in
    function automatic t_coord rand_coord();
        case ($urandom_range(0, 7))
            0:       return COORD_MIN;
            1:       return COORD_MAX;
            2:       return t_coord'(int'($urandom_range(0, 8)) - 4);
            default: return t_coord'($urandom());
        endcase
    endfunction

    // one segment word; entered and left at a falling edge
    task automatic send_segment(input t_coord sx, input t_coord sy, input t_coord mx,
                                input t_coord my, input t_coord ex, input t_coord ey);
        int gap;
        gap = draw_wait(send_calm);
        if (gap > 0) begin
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        // start_x sits in the lowest bits
        s_axis_tdata  = {ey, ex, my, mx, sy, sx};
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        sb.note_segment(sx, sy, mx, my, ex, ey);
        @(negedge i_clk);
    endtask

    task automatic send_random_segment();
        send_segment(rand_coord(), rand_coord(), rand_coord(),
                     rand_coord(), rand_coord(), rand_coord());
    endtask

    // hold off until every owed point word is back
    task automatic drain();
        s_axis_tvalid = 1'b0;
        while (sb.pending() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // only called with the pipe empty
    task automatic write_steps(input int value);
        i_cfg_we    = 1'b1;
        i_cfg_wdata = t_steps'(value);
        @(negedge i_clk);
        i_cfg_we    = 1'b0;
        sb.steps    = t_steps'(value);
        steps_writes++;
    endtask

    // -----------------------------------------------------------------------
    // Point word receiver
    // -----------------------------------------------------------------------
    initial begin
        int stall;
        recv_calm = 0;
        m_axis_tready = 1'b0;
        @(posedge i_rst_n);
        @(negedge i_clk);
        forever begin
            stall = draw_wait(recv_calm);
            if (stall > 0) begin
                m_axis_tready = 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            m_axis_tready = 1'b1;
            @(posedge i_clk);
            while (!m_axis_tvalid)
                @(posedge i_clk);
            sb.check_point(m_axis_tdata, m_axis_tlast);
            @(negedge i_clk);
        end
    end

    // -----------------------------------------------------------------------
    // Stimulus
    // -----------------------------------------------------------------------
    initial begin
        int ph;
        int k;
        int steps_pick;
        sb            = new();
        send_calm     = 0;
        steps_writes  = 0;
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_wdata   = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // reset default of 16 steps, register untouched
        send_segment('0, '0, '0, '0, '0, '0);
        send_segment(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN);
        send_segment(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX);
        send_segment(COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX);
        send_segment(COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN);
        // i = 8 lands on +0.5 in x and -0.5 in y
        send_segment(12'sd0, 12'sd0, 12'sd1, -12'sd1, 12'sd0, 12'sd0);
        drain();

        // two steps: midpoint ties, alternating bit patterns
        write_steps(2);
        send_segment(12'sd0, 12'sd0, 12'sd1, -12'sd1, 12'sd0, 12'sd0);
        send_segment(-12'sd3, 12'sd3, 12'sd0, 12'sd0, 12'sd1, -12'sd1);
        send_segment(t_coord'(12'hAAA), t_coord'(12'h555), t_coord'(12'h555),
                     t_coord'(12'hAAA), t_coord'(12'hAAA), t_coord'(12'h555));
        drain();

        // zero steps behaves as one: start and end only
        write_steps(0);
        send_segment(12'sd100, -12'sd100, COORD_MAX, COORD_MIN, -12'sd7, 12'sd9);
        send_segment(COORD_MIN, COORD_MAX, 12'sd0, 12'sd0, COORD_MAX, COORD_MIN);
        drain();

        write_steps(1);
        send_segment(12'sd5, 12'sd6, 12'sd7, 12'sd8, -12'sd5, -12'sd6);
        drain();

        // largest step count
        write_steps(MAX_STEPS);
        send_segment(COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX);
        send_segment(12'sd0, 12'sd0, 12'sd1, -12'sd1, 12'sd0, 12'sd0);
        drain();
        directed_segs = sb.segments;

        // random phases, each with its own step count
        for (ph = 0; ph < RANDOM_PHASES; ph++) begin
            case (ph)
                0:       steps_pick = $urandom_range(1, 8);
                1:       steps_pick = MAX_STEPS;
                3:       steps_pick = 0;
                4:       steps_pick = DEF_STEPS;
                default: steps_pick = $urandom_range(1, MAX_STEPS);
            endcase
            write_steps(steps_pick);
            for (k = 0; k < SEGS_PER_PHASE; k++) begin
                // one mid-phase hold-off until everything is back
                if (ph == 2 && k == SEGS_PER_PHASE / 2)
                    drain();
                send_random_segment();
            end
            drain();
        end

        repeat (TAIL_CYCLES) @(negedge i_clk);

        $display("Checked %0d curve segments (%0d directed) and %0d point words",
                 sb.segments, directed_segs, sb.points);
        $display("over %0d steps settings incl. 0, 1, 2, 16 and 63, with random stalls both sides",
                 steps_writes + 1);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

>>> sim.f
+incdir+rtl/core
rtl/core/qbt_pkg.sv
rtl/core/qbt_div.sv
rtl/core/qbt_front.sv
rtl/core/qbt_fifo.sv
rtl/core/qbt_back.sv
rtl/core/quadratic_bezier_tessellator.sv
sim/quadratic_bezier_tessellator_tb.sv
